@@ sv/rrss_pkg.sv @@
`default_nettype none
package rrss_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int PERIOD_W = 16;
    localparam int SLOTS_W  = 11;
    localparam int WORD_W   = 32;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1;
    localparam logic [SLOTS_W-1:0]  SLOTS_RST  = 11'd1024;
    localparam logic [WORD_W-1:0]   EMPTY_RST  = 32'd0;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_SLOTS  = 2'd1;
    localparam logic [1:0] REG_EMPTY  = 2'd2;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STALE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FLUSHED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ    = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] time_s;
        logic [WORD_W-1:0] sample_word;
    } t_item;

    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [TIME_W-1:0]   quo;
        logic [PERIOD_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PAD,
        S_WRITE,
        S_OLD,
        S_OLD2,
        S_RMUL,
        S_RCLAMP,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

@@ sv/rrss_ifs.sv @@
`default_nettype none
interface rrss_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] time_s;
    logic [31:0] sample_word;
    modport source(output valid, cmd, time_s, sample_word, input ready);
    modport sink(input valid, cmd, time_s, sample_word, output ready);
endinterface

interface rrss_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] value_word;
    logic [9:0]  slot_index;
    logic [31:0] slot_time;
    logic [31:0] oldest_time;
    logic [31:0] latest_time;
    modport source(output valid, status, value_word, slot_index, slot_time, oldest_time,
                   latest_time, input ready);
    modport sink(input valid, status, value_word, slot_index, slot_time, oldest_time,
                 latest_time, output ready);
endinterface
`default_nettype wire

@@ sv/rrss_front.sv @@
`default_nettype none
module rrss_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    rrss_item_if.sink           i_item,
    input  wire                 i_clearing,
    input  wire                 i_q_pop,
    output rrss_pkg::t_item     o_q_item,
    output logic                o_q_valid
);

    rrss_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;

    assign i_item.ready = (r_cnt != 2'd2) && !i_clearing;
    assign push         = i_item.valid && i_item.ready;
    assign o_q_valid    = (r_cnt != 2'd0);
    assign o_q_item     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{cmd: i_item.cmd, time_s: i_item.time_s,
                           sample_word: i_item.sample_word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/rrss_div.sv @@
`default_nettype none
module rrss_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rrss_pkg::t_div_req  i_req,
    output rrss_pkg::t_div_rsp  o_rsp
);

    logic [rrss_pkg::TIME_W-1:0]   r_quo;
    logic [rrss_pkg::PERIOD_W-1:0] r_rem;
    logic [rrss_pkg::PERIOD_W-1:0] r_dvs;
    logic [5:0]                    r_cnt;
    logic                          r_done;
    logic [rrss_pkg::PERIOD_W:0]   trial;
    logic                          ge;

    assign trial = {r_rem, r_quo[rrss_pkg::TIME_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});

    assign o_rsp = '{done: r_done, quo: r_quo, rem: r_rem};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_cnt != 6'd0) begin
            r_quo <= {r_quo[rrss_pkg::TIME_W-2:0], ge};
            r_rem <= ge ? rrss_pkg::PERIOD_W'(trial - {1'b0, r_dvs})
                        : trial[rrss_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 6'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (i_req.start) begin
                r_cnt <= 6'(rrss_pkg::TIME_W);
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/rrss_back.sv @@
`default_nettype none
module rrss_back #(
    parameter int DEPTH = rrss_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1),
    localparam int PW = CW + rrss_pkg::PERIOD_W
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_flush,
    input  wire [CW-1:0]                     i_n,
    input  wire [rrss_pkg::PERIOD_W-1:0]     i_p,
    input  wire [rrss_pkg::WORD_W-1:0]       i_empty,
    input  rrss_pkg::t_item                  i_q_item,
    input  wire                              i_q_valid,
    output logic                             o_q_pop,
    output logic                             o_clearing,
    output rrss_pkg::t_div_req               o_div,
    input  rrss_pkg::t_div_rsp               i_div,
    rrss_res_if.source                       o_res
);

    rrss_pkg::t_state                 r_state;
    rrss_pkg::t_state                 n_state;
    rrss_pkg::t_item                  r_item;
    logic [rrss_pkg::WORD_W-1:0]      r_mem [DEPTH];
    logic [rrss_pkg::WORD_W-1:0]      r_val;
    logic [AW-1:0]                    r_wslot;
    logic [CW-1:0]                    r_filled;
    logic [rrss_pkg::TIME_W-1:0]      r_last;
    logic [rrss_pkg::TIME_W-1:0]      r_oldest;
    logic [AW-1:0]                    r_clr;
    logic                             r_clr_store;
    logic [CW-1:0]                    r_pads;
    logic [rrss_pkg::STATUS_W-1:0]    r_status;
    logic [AW-1:0]                    r_slot;
    logic [rrss_pkg::TIME_W-1:0]      r_stime;
    logic [PW-1:0]                    r_prod;

    logic [AW-1:0]                    ws_eff;
    logic [AW-1:0]                    ws_next;
    logic [AW-1:0]                    ls;
    logic [AW-1:0]                    fs;
    logic [AW-1:0]                    n_m1;
    logic [CW-1:0]                    fill_min;
    logic [CW-1:0]                    fill_inc;
    logic [CW-1:0]                    slot_span;
    logic [AW-1:0]                    slot_c;
    logic [32:0]                      ls33;
    logic [32:0]                      n33;
    logic [32:0]                      d33;
    logic                             is_store;
    logic                             stale;
    logic                             has_gap;
    logic                             rd_latest;
    logic                             rd_oldest;
    logic                             need_div;
    logic                             gap_big;
    logic                             clr_last;
    logic                             mem_we;
    logic [AW-1:0]                    mem_addr;
    logic [rrss_pkg::WORD_W-1:0]      mem_data;
    logic                             mem_re;

    // ring pointers
    always_comb begin
        n_m1      = AW'(i_n - CW'(1));
        ws_eff    = (CW'(r_wslot) < i_n) ? r_wslot : '0;
        ws_next   = ((CW'(ws_eff) + CW'(1)) >= i_n) ? '0 : ws_eff + AW'(1);
        ls        = (ws_eff == '0) ? n_m1 : ws_eff - AW'(1);
        fs        = (r_filled >= i_n) ? ws_eff : '0;
        fill_min  = (r_filled < i_n) ? r_filled : i_n;
        fill_inc  = (r_filled < i_n) ? r_filled + CW'(1) : r_filled;
        slot_span = (r_slot > ls) ? CW'(ls) + i_n - CW'(r_slot) : CW'(ls - r_slot);
        clr_last  = (r_clr == AW'(DEPTH - 1));
    end

    // classification of the item at the queue head
    always_comb begin
        is_store  = (i_q_item.cmd == rrss_pkg::CMD_STORE);
        stale     = (i_q_item.time_s <= r_last);
        has_gap   = (r_last != '0) &&
                    ({1'b0, i_q_item.time_s} > ({1'b0, r_last} + 33'(i_p)));
        rd_latest = (i_q_item.time_s >= r_last);
        rd_oldest = (i_q_item.time_s <= r_oldest);
        need_div  = is_store ? (!stale && has_gap) : (!rd_latest && !rd_oldest);
    end

    // divider result handling
    always_comb begin
        gap_big = ((33'(i_div.quo) + 33'(i_div.rem == (i_p - 16'd1)))) >= 33'(i_n);
        ls33    = 33'(ls);
        n33     = 33'(i_n);
        d33     = 33'(i_div.quo);
        if (ls33 >= d33) begin
            slot_c = AW'(ls33 - d33);
        end else if (d33 <= ls33 + n33) begin
            slot_c = AW'(ls33 + n33 - d33);
        end else begin
            slot_c = n_m1;
        end
        if (CW'(slot_c) >= i_n) begin
            slot_c = n_m1;
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_flush) begin
            n_state = rrss_pkg::S_CLEAR;
        end else begin
            case (r_state)
                rrss_pkg::S_CLEAR: begin
                    if (clr_last) begin
                        n_state = r_clr_store ? rrss_pkg::S_WRITE : rrss_pkg::S_IDLE;
                    end
                end
                rrss_pkg::S_IDLE: begin
                    if (i_q_valid) begin
                        if (need_div) begin
                            n_state = rrss_pkg::S_DIV;
                        end else if (is_store) begin
                            n_state = stale ? rrss_pkg::S_OLD : rrss_pkg::S_WRITE;
                        end else begin
                            n_state = rrss_pkg::S_RMUL;
                        end
                    end
                end
                rrss_pkg::S_DIV: begin
                    if (i_div.done) begin
                        if (r_item.cmd == rrss_pkg::CMD_READ) begin
                            n_state = rrss_pkg::S_RMUL;
                        end else begin
                            n_state = gap_big ? rrss_pkg::S_CLEAR : rrss_pkg::S_PAD;
                        end
                    end
                end
                rrss_pkg::S_PAD: begin
                    if (r_pads == CW'(1)) begin
                        n_state = rrss_pkg::S_WRITE;
                    end
                end
                rrss_pkg::S_WRITE:  n_state = rrss_pkg::S_OLD;
                rrss_pkg::S_OLD:    n_state = rrss_pkg::S_OLD2;
                rrss_pkg::S_OLD2:   n_state = rrss_pkg::S_OUT;
                rrss_pkg::S_RMUL:   n_state = rrss_pkg::S_RCLAMP;
                rrss_pkg::S_RCLAMP: n_state = rrss_pkg::S_OUT;
                rrss_pkg::S_OUT: begin
                    if (o_res.ready) begin
                        n_state = rrss_pkg::S_IDLE;
                    end
                end
                default: n_state = rrss_pkg::S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_q_pop      = (r_state == rrss_pkg::S_IDLE) && i_q_valid && !i_flush;
        o_clearing   = (r_state == rrss_pkg::S_CLEAR);
        o_div.start  = o_q_pop && need_div;
        o_div.dividend = is_store ? i_q_item.time_s - r_last - 32'd1
                                  : r_last - i_q_item.time_s;
        o_div.divisor  = i_p;
        mem_re   = (r_state == rrss_pkg::S_RMUL);
        mem_we   = 1'b0;
        mem_addr = ws_eff;
        mem_data = i_empty;
        case (r_state)
            rrss_pkg::S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
            end
            rrss_pkg::S_PAD: begin
                mem_we = 1'b1;
            end
            rrss_pkg::S_WRITE: begin
                mem_we   = 1'b1;
                mem_data = r_item.sample_word;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_data;
        end
        if (mem_re) begin
            r_val <= r_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        case (r_state)
            rrss_pkg::S_IDLE: begin
                if (o_q_pop) begin
                    r_slot  <= '0;
                    r_stime <= '0;
                    if (is_store) begin
                        r_status <= stale ? rrss_pkg::ST_STALE : rrss_pkg::ST_STORED;
                    end else begin
                        r_status <= rrss_pkg::ST_READ;
                        r_slot   <= rd_latest ? ls : fs;
                    end
                end
            end
            rrss_pkg::S_DIV: begin
                if (i_div.done) begin
                    if (r_item.cmd == rrss_pkg::CMD_READ) begin
                        r_slot <= slot_c;
                    end else if (gap_big) begin
                        r_status <= rrss_pkg::ST_FLUSHED;
                    end else begin
                        r_pads <= CW'(i_div.quo);
                    end
                end
            end
            rrss_pkg::S_PAD: begin
                r_pads <= r_pads - CW'(1);
            end
            rrss_pkg::S_WRITE: begin
                r_slot  <= ws_eff;
                r_stime <= r_item.time_s;
            end
            rrss_pkg::S_OLD: begin
                r_prod <= PW'(fill_min) * PW'(i_p);
            end
            rrss_pkg::S_RMUL: begin
                r_prod <= PW'(slot_span) * PW'(i_p);
            end
            rrss_pkg::S_RCLAMP: begin
                r_stime <= (64'(r_prod) > 64'(r_last - r_oldest)) ? r_oldest
                                                                  : r_last - 32'(r_prod);
            end
            default: r_pads <= r_pads;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrss_pkg::S_CLEAR;
            r_clr       <= '0;
            r_clr_store <= 1'b0;
            r_wslot     <= '0;
            r_filled    <= '0;
            r_last      <= '0;
            r_oldest    <= '0;
        end else begin
            r_state <= n_state;
            if (i_flush) begin
                r_clr       <= '0;
                r_clr_store <= 1'b0;
                r_wslot     <= '0;
                r_filled    <= '0;
                r_last      <= '0;
                r_oldest    <= '0;
            end else begin
                case (r_state)
                    rrss_pkg::S_CLEAR: begin
                        r_clr <= clr_last ? '0 : r_clr + AW'(1);
                        if (clr_last) begin
                            r_clr_store <= 1'b0;
                        end
                    end
                    rrss_pkg::S_DIV: begin
                        if (i_div.done && r_item.cmd == rrss_pkg::CMD_STORE && gap_big) begin
                            r_clr       <= '0;
                            r_clr_store <= 1'b1;
                            r_wslot     <= '0;
                            r_filled    <= '0;
                            r_last      <= '0;
                            r_oldest    <= '0;
                        end
                    end
                    rrss_pkg::S_PAD: begin
                        r_wslot  <= ws_next;
                        r_filled <= fill_inc;
                    end
                    rrss_pkg::S_WRITE: begin
                        r_wslot  <= ws_next;
                        r_filled <= fill_inc;
                        r_last   <= r_item.time_s;
                    end
                    rrss_pkg::S_OLD2: begin
                        r_oldest <= (64'(r_prod) > 64'(r_last)) ? '0 : r_last - 32'(r_prod);
                    end
                    default: r_clr <= r_clr;
                endcase
            end
        end
    end

    assign o_res.valid       = (r_state == rrss_pkg::S_OUT);
    assign o_res.status      = r_status;
    assign o_res.value_word  = (r_status == rrss_pkg::ST_READ) ? r_val : '0;
    assign o_res.slot_index  = rrss_pkg::SLOT_W'(r_slot);
    assign o_res.slot_time   = r_stime;
    assign o_res.oldest_time = r_oldest;
    assign o_res.latest_time = r_last;

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != rrss_pkg::S_IDLE))
        else $error("item taken from queue but sequencer stayed idle");

    a_write_sets_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrss_pkg::S_WRITE && !i_flush) |=> (r_last == $past(r_item.time_s)))
        else $error("latest time not taken from stored sample");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrss_pkg::S_CLEAR && clr_last && !i_flush) |=>
        (r_state == rrss_pkg::S_IDLE || r_state == rrss_pkg::S_WRITE))
        else $error("clearing pass did not finish");

    a_transfer_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !i_flush) |=> (r_state == rrss_pkg::S_IDLE))
        else $error("result transfer did not free the sequencer");

endmodule
`default_nettype wire

@@ sv/round_robin_sample_store.sv @@
// Time-stamped circular sample store. A stale store item is not written. A store after a gap
// of more than one period runs the bit-serial divider and then pads each skipped slot with the
// empty word, and a gap of the ring size or more instead runs a clearing pass over all DEPTH
// slots. A read needs the divider only when its time falls strictly inside the stored span.
// After reset and after every register write the store runs a clearing pass, during which no
// item is taken in; register writes are still accepted. A two-entry queue takes items in while
// a result waits.
`default_nettype none
module round_robin_sample_store #(
    parameter int DEPTH = rrss_pkg::DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    rrss_item_if.sink                    i_item,
    rrss_res_if.source                   o_res,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [rrss_pkg::APB_AW-1:0]   paddr,
    input  wire [rrss_pkg::APB_DW-1:0]   pwdata,
    output logic [rrss_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [rrss_pkg::PERIOD_W-1:0] r_period;
    logic [rrss_pkg::SLOTS_W-1:0]  r_slots;
    logic [rrss_pkg::WORD_W-1:0]   r_empty;
    logic                          wr;
    logic                          flush;
    logic [1:0]                    idx;
    logic [CW-1:0]                 eff_n;
    logic [rrss_pkg::PERIOD_W-1:0] eff_p;
    rrss_pkg::t_item               q_item;
    logic                          q_valid;
    logic                          q_pop;
    logic                          clearing;
    rrss_pkg::t_div_req            div_req;
    rrss_pkg::t_div_rsp            div_rsp;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign flush  = wr && (idx == rrss_pkg::REG_PERIOD || idx == rrss_pkg::REG_SLOTS ||
                           idx == rrss_pkg::REG_EMPTY);

    always_comb begin
        case (idx)
            rrss_pkg::REG_PERIOD: prdata = 32'(r_period);
            rrss_pkg::REG_SLOTS:  prdata = 32'(r_slots);
            rrss_pkg::REG_EMPTY:  prdata = r_empty;
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= rrss_pkg::PERIOD_RST;
            r_slots  <= rrss_pkg::SLOTS_RST;
            r_empty  <= rrss_pkg::EMPTY_RST;
        end else if (wr) begin
            case (idx)
                rrss_pkg::REG_PERIOD: r_period <= pwdata[rrss_pkg::PERIOD_W-1:0];
                rrss_pkg::REG_SLOTS:  r_slots  <= pwdata[rrss_pkg::SLOTS_W-1:0];
                rrss_pkg::REG_EMPTY:  r_empty  <= pwdata;
                default:              r_empty  <= r_empty;
            endcase
        end
    end

    always_comb begin
        if (r_slots == '0) begin
            eff_n = CW'(1);
        end else if (32'(r_slots) > 32'(DEPTH)) begin
            eff_n = CW'(DEPTH);
        end else begin
            eff_n = CW'(r_slots);
        end
        eff_p = (r_period == '0) ? 16'd1 : r_period;
    end

    rrss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_clearing (clearing),
        .i_q_pop    (q_pop),
        .o_q_item   (q_item),
        .o_q_valid  (q_valid)
    );

    rrss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rrss_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flush    (flush),
        .i_n        (eff_n),
        .i_p        (eff_p),
        .i_empty    (r_empty),
        .i_q_item   (q_item),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_div      (div_req),
        .i_div      (div_rsp),
        .o_res      (o_res)
    );

endmodule
`default_nettype wire
